// ===== rtl/core/sha256_stream_hash_defines.svh =====
// assertion macros for the streaming sha-256 hasher checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define S256_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define S256_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/s256_pkg.sv =====
// shared types, constants and round functions of the sha-256 stream hasher
// no dependencies
package s256_pkg;

  localparam int BlkQueueDepth = 2;
  localparam int BlockWords    = 16;
  localparam int Rounds        = 64;
  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // one 512-bit block for the compression engine
  typedef struct packed {
    logic [BlockWords-1:0][31:0] words;
    logic                        final_blk;
  } blk_entry_t;

  localparam logic [7:0][31:0] InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/core/s256_front.sv =====
// front end: packs message bytes into blocks and builds the padded tail blocks
// depends on s256_pkg
module s256_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  s256_pkg::in_item_t    in_data,
  output logic                  q_push,
  output s256_pkg::blk_entry_t  q_data,
  input  logic                  q_full
);
  import s256_pkg::*;

  typedef enum logic [2:0] {
    F_TAKE = 3'b001,
    F_PAD  = 3'b010,
    F_LEN  = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      bits_r, bits_nxt;
  logic [63:0][7:0] bytes_r, bytes_nxt;
  logic             accept;
  logic [15:0][31:0] full_words, pad_words, len_words;

  assign in_full = (state_r != F_TAKE) || q_full;
  assign accept  = in_push && !in_full;

  // byte write into the block buffer
  always_comb begin
    bytes_nxt = bytes_r;
    if (accept && in_data.byte_present) begin
      bytes_nxt[fill_r] = in_data.message_byte;
    end
  end

  // candidate blocks: full data, padded tail, length-only tail
  always_comb begin
    for (int k = 0; k < BlockWords; k++) begin
      full_words[k] = {bytes_nxt[4*k], bytes_nxt[4*k+1], bytes_nxt[4*k+2], bytes_nxt[4*k+3]};
      len_words[k]  = '0;
    end
    for (int k = 0; k < BlockWords; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (6'(4*k+j) < fill_r) begin
          pad_words[k][31-8*j -: 8] = bytes_r[4*k+j];
        end else if (6'(4*k+j) == fill_r) begin
          pad_words[k][31-8*j -: 8] = PadMark;
        end else begin
          pad_words[k][31-8*j -: 8] = 8'h00;
        end
      end
    end
    if (fill_r < 6'd56) begin
      pad_words[14] = bits_r[63:32];
      pad_words[15] = bits_r[31:0];
    end
    len_words[14] = bits_r[63:32];
    len_words[15] = bits_r[31:0];
  end

  // sequencing of data and tail blocks
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    bits_nxt       = bits_r;
    q_push         = 1'b0;
    q_data.words   = full_words;
    q_data.final_blk = 1'b0;
    unique case (state_r)
      F_TAKE: begin
        if (accept) begin
          if (in_data.byte_present) begin
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
            q_push   = (fill_r == 6'd63);
          end
          if (in_data.end_of_message) begin
            state_nxt = F_PAD;
          end
        end
      end
      F_PAD: begin
        q_data.words     = pad_words;
        q_data.final_blk = (fill_r < 6'd56);
        if (!q_full) begin
          q_push = 1'b1;
          if (fill_r < 6'd56) begin
            fill_nxt  = '0;
            bits_nxt  = '0;
            state_nxt = F_TAKE;
          end else begin
            state_nxt = F_LEN;
          end
        end
      end
      F_LEN: begin
        q_data.words     = len_words;
        q_data.final_blk = 1'b1;
        if (!q_full) begin
          q_push    = 1'b1;
          fill_nxt  = '0;
          bits_nxt  = '0;
          state_nxt = F_TAKE;
        end
      end
      default: state_nxt = F_TAKE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_TAKE;
      fill_r  <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
    end
  end

  // block buffer
  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

// ===== rtl/core/s256_blkq.sv =====
// short queue of whole blocks between the front end and the compression engine
// depends on s256_pkg
module s256_blkq #(
  parameter int Depth = s256_pkg::BlkQueueDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  s256_pkg::blk_entry_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output s256_pkg::blk_entry_t  head,
  output logic                  empty
);
  import s256_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  blk_entry_t      slot_r [Depth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;

  assign full  = (cnt_r == CntW'(Depth));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/s256_back.sv =====
// back end: 64-round compression, one round a cycle, and the digest buffer
// depends on s256_pkg
module s256_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  s256_pkg::blk_entry_t  q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output s256_pkg::out_item_t   out_data
);
  import s256_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_ADD  = 3'b100
  } bstate_t;

  bstate_t     state_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [31:0] chain_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [BlockWords];
  logic [31:0] dig_r [8];
  logic        dvalid_r;
  logic [2:0]  oidx_r;
  logic [31:0] t1, t2, w_new;
  logic [31:0] sum [8];

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  // round and schedule datapath
  always_comb begin
    t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + RoundK[rnd_r] + w_r[0];
    t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = sml_sig1(w_r[14]) + w_r[9] + sml_sig0(w_r[1]) + w_r[0];
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_r[i] + v_r[i];
    end
  end

  // engine sequencing and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      rnd_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= InitHash[i];
      end
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            state_r <= B_RUN;
            rnd_r   <= '0;
          end
        end
        B_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(Rounds - 1)) begin
            state_r <= B_ADD;
          end
        end
        B_ADD: begin
          if (!fin_r) begin
            for (int i = 0; i < 8; i++) begin
              chain_r[i] <= sum[i];
            end
            state_r <= B_IDLE;
          end else if (!dvalid_r) begin
            for (int i = 0; i < 8; i++) begin
              chain_r[i] <= InitHash[i];
            end
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fin_r <= q_head.final_blk;
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[i];
      end
      for (int i = 0; i < BlockWords; i++) begin
        w_r[i] <= q_head.words[i];
      end
    end else if (state_r == B_RUN) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BlockWords-1] <= w_new;
    end
  end

  // digest buffer and word counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= 1'b0;
      oidx_r   <= '0;
    end else if (state_r == B_ADD && fin_r && !dvalid_r) begin
      dvalid_r <= 1'b1;
      oidx_r   <= '0;
    end else if (out_pop && dvalid_r) begin
      oidx_r <= oidx_r + 3'd1;
      if (oidx_r == 3'd7) begin
        dvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_ADD && fin_r && !dvalid_r) begin
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= sum[i];
      end
    end
  end

  assign out_empty            = !dvalid_r;
  assign out_data.digest_word = dig_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == 3'd7);

endmodule

// ===== rtl/core/sha256_stream_hash.sv =====
// top level of the streaming sha-256 hasher
// depends on s256_pkg, s256_front, s256_blkq, s256_back
//
// usage
//   input queue: one transaction per message byte (push/full). byte_present
//   marks a real byte; end_of_message closes the message after that byte.
//   an item with end_of_message and no byte hashes what has come so far,
//   the empty message at the start of a message.
//   result queue: eight transactions per message (empty/pop), h0 first,
//   word_index 0 to 7, last_word set on the eighth.
//   throughput: one byte a cycle while the block queue has room and no
//   tail block is being built; the compression engine works each 64-byte
//   block in order (load, 64 rounds, chaining add). the front end fills
//   the next block while one compresses.
//   the end item needs one or two tail blocks, and the first digest word
//   appears once the engine has compressed the last of them.
//   a stalled receiver holds the digest; the engine may finish later blocks
//   but waits before a final chaining add until all eight words are popped.
//   reset: synchronous, active low; clears all queues, restarts the
//   chaining value at the standard initial hash and the length at zero.
module sha256_stream_hash #(
  parameter int BlkQueueDepth = s256_pkg::BlkQueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  s256_pkg::in_item_t   in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output s256_pkg::out_item_t  out_data
);
  import s256_pkg::*;

  logic       q_push, q_full, q_pop, q_empty;
  blk_entry_t q_wdata, q_head;

  // byte packing and padding
  s256_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // block queue
  s256_blkq #(
    .Depth (BlkQueueDepth)
  ) u_blkq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // compression and digest output
  s256_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/s256_checker.sv =====
// port-level checks of the streaming sha-256 hasher, bound to the top level
// depends on s256_pkg and sha256_stream_hash_defines.svh
`include "sha256_stream_hash_defines.svh"

module s256_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_push,
  input logic                 in_full,
  input s256_pkg::in_item_t   in_data,
  input logic                 out_empty,
  input logic                 out_pop,
  input s256_pkg::out_item_t  out_data
);
  import s256_pkg::*;

  // last word flag goes with the eighth word only
  `S256_ASSERT_NOW(a_last_idx, !out_empty, out_data.last_word == (out_data.word_index == 3'd7), "last_word does not match word_index")

  // words of one digest come in order without gaps
  `S256_ASSERT_NEXT(a_idx_seq, !out_empty && out_pop && !out_data.last_word, !out_empty && out_data.word_index == $past(out_data.word_index) + 3'd1, "digest word order broken")

  // a digest starts at word zero
  `S256_ASSERT_NEXT(a_idx_start, out_empty, out_empty || out_data.word_index == 3'd0, "digest does not start at word zero")

  // a waiting result holds while not popped
  `S256_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_data), "waiting result changed")

  // input stalls while the tail blocks of a message are built
  `S256_ASSERT_NEXT(a_end_stall, in_push && !in_full && in_data.end_of_message, in_full, "input not stalled after end of message")

endmodule

bind sha256_stream_hash s256_checker u_s256_checker (.*);

// ===== tb/sv/tb_sha256_stream_hash.sv =====
// self-checking testbench for the streaming sha-256 hasher sha256_stream_hash
// depends on s256_pkg for the transaction types; predicts digests in sv
`timescale 1ns / 1ps

module tb_sha256_stream_hash;
  import s256_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;

  sha256_stream_hash uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // round constants and initial hash, own copy
  logic [31:0] k_tab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  logic [31:0] iv_tab [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // predictor state
  logic [31:0] hash_state [8];
  logic [31:0] blk [16];
  logic [5:0]  fill_pos;
  logic [63:0] bit_len;
  out_item_t   digest_q [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  busy_phase = 1'b1;   // random idling enabled
  int  idle_pct = 37;

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  function automatic void place_byte(int pos, logic [7:0] b);
    blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_state[i] = iv_tab[i];
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill_pos = '0;
    bit_len = '0;
  endtask

  // advance the predictor by one accepted item
  task automatic predict_item(in_item_t it);
    out_item_t r;
    int pos;
    if (it.byte_present) begin
      place_byte(fill_pos, it.message_byte);
      bit_len += 64'd8;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) compress_blk();
    end
    if (it.end_of_message) begin
      pos = fill_pos;
      place_byte(pos, 8'h80);
      for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
      if (pos >= 56) begin
        compress_blk();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        r.digest_word = hash_state[i];
        r.word_index = i[2:0];
        r.last_word = (i == 7);
        digest_q = {digest_q, r};
      end
      for (int i = 0; i < 8; i++) hash_state[i] = iv_tab[i];
      fill_pos = '0;
      bit_len = '0;
    end
  endtask

  // send one transaction, with random idle cycles before it
  // push stays raised on return; idling drops it, waiting for room keeps it raised
  task automatic send_item(logic [7:0] b, bit present, bit eom);
    in_item_t it;
    while (busy_phase && $urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    it.message_byte = b;
    it.byte_present = present;
    it.end_of_message = eom;
    in_data <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic send_message(int len, int mode);
    for (int i = 0; i < len; i++)
      send_item(mode == 0 ? 8'($urandom) : (mode == 1 ? 8'hff : 8'h00),
                1'b1, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(negedge clk);
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  // empty message, a one-byte and a two-byte message, all-ones and all-zero bytes
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b1);
    send_item(8'h55, 1'b0, 1'b0);
    send_message(3, 1);
    send_message(2, 2);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
  endtask

  // length that needs a second tail block, and a block closed by the end byte
  task automatic test_tail_blocks();
    send_message(56, 0);
    // byte and end together closing a full block
    for (int i = 0; i < 63; i++) send_item(8'($urandom), 1'b1, 1'b0);
    send_item(8'hc3, 1'b1, 1'b1);
  endtask

  // random messages, mostly short, with noise items mixed in
  task automatic test_random(int n_items);
    int sent = 0;
    int len;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b0);
      end
      if ($urandom_range(1)) send_item(8'($urandom), 1'b1, 1'b1);
      else send_item(8'($urandom), 1'b0, 1'b1);
      sent += len + 1;
    end
  endtask

  // sender holds off until all digests are out, then a burst with no idling
  task automatic test_back_to_back();
    wait_drained();
    busy_phase = 1'b0;
    test_random(12);
    busy_phase = 1'b1;
  endtask

  // result checker and random pop
  always @(posedge clk) begin
    out_item_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_pop && !out_empty) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest transaction %h", out_data);
        fail_count++;
      end else begin
        exp_r = digest_q.pop_front();
        if (out_data.digest_word !== exp_r.digest_word) begin
          $error("digest_word exp %h got %h", exp_r.digest_word, out_data.digest_word);
          fail_count++;
        end
        if (out_data.word_index !== exp_r.word_index) begin
          $error("word_index exp %0d got %0d", exp_r.word_index, out_data.word_index);
          fail_count++;
        end
        if (out_data.last_word !== exp_r.last_word) begin
          $error("last_word exp %0d got %0d", exp_r.last_word, out_data.last_word);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= !(busy_phase && $urandom_range(99) < idle_pct);
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("tb_sha256_stream_hash: errors");
      $finish;
    end
  end

  initial begin
    hash_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_tail_blocks();
    test_random(12);
    test_back_to_back();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("tb_sha256_stream_hash: clean");
    end else begin
      $display("tb_sha256_stream_hash: errors");
    end
    $finish;
  end

endmodule
